[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ITM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ITM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define ITM_ASSERT(label, clk, rst_n, prop, msg)
`define ITM_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[src/itm_pkg.sv]
// ----------------------------------------------------------------------------
// Triangular Ising Metropolis package
// Shared widths, operation and register codes, neighbor codes and the
// configuration bundle.
// ----------------------------------------------------------------------------
package itm_pkg;

  localparam int ITM_ROWS = 16;
  localparam int ITM_COLS = 16;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 4;
  localparam int FRAC_W     = 32;
  localparam int LEVEL_W    = 33;
  localparam int ENERGY_W   = 11;
  localparam int SUM_W      = 40;
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 5;

  localparam int ENERGY_MAX = 768;
  localparam int ENERGY_MIN = -768;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE_Q32 = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENERGY = 2'd1,
    OP_TRIAL  = 2'd2,
    OP_ACCUM  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_LEVEL_ONE   = 2'd0,
    REG_LEVEL_TWO   = 2'd1,
    REG_LEVEL_THREE = 2'd2,
    REG_COUPLING    = 2'd3
  } reg_e;

  // Trial reads use these codes in order as the step count.
  typedef enum logic [2:0] {
    NB_CENTER            = 3'd0,
    NB_NEXT_ROW          = 3'd1,
    NB_PREV_ROW          = 3'd2,
    NB_NEXT_ROW_PREV_COL = 3'd3,
    NB_PREV_ROW_NEXT_COL = 3'd4,
    NB_NEXT_COL          = 3'd5,
    NB_PREV_COL          = 3'd6
  } nbr_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_one;
    logic [LEVEL_W-1:0] level_two;
    logic [LEVEL_W-1:0] level_three;
    logic               coupling_negative;
  } cfg_t;

endpackage

[src/itm_in_if.sv]
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
interface itm_in_if import itm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [COORD_W-1:0]   row;
  logic [COORD_W-1:0]   col;
  logic                 spin_up;
  logic [FRAC_W-1:0]    random_fraction;

  modport source (
    output valid, operation, row, col, spin_up, random_fraction,
    input  ready
  );

  modport sink (
    input  valid, operation, row, col, spin_up, random_fraction,
    output ready
  );
endinterface

[src/itm_out_if.sv]
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface itm_out_if import itm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       spin_after;
  logic                       accepted;
  logic signed [ENERGY_W-1:0] total_energy;
  logic signed [SUM_W-1:0]    energy_sum;

  modport source (
    output valid, spin_after, accepted, total_energy, energy_sum,
    input  ready
  );

  modport sink (
    input  valid, spin_after, accepted, total_energy, energy_sum,
    output ready
  );
endinterface

[src/itm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the acceptance levels and coupling sign.
// ----------------------------------------------------------------------------
module itm_cfg_regs import itm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LEVEL_ONE:   cfg_d.level_one         = pwdata[LEVEL_W-1:0];
        REG_LEVEL_TWO:   cfg_d.level_two         = pwdata[LEVEL_W-1:0];
        REG_LEVEL_THREE: cfg_d.level_three       = pwdata[LEVEL_W-1:0];
        REG_COUPLING:    cfg_d.coupling_negative = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEVEL_ONE:   prdata = CFG_DW'(cfg_q.level_one);
      REG_LEVEL_TWO:   prdata = CFG_DW'(cfg_q.level_two);
      REG_LEVEL_THREE: prdata = CFG_DW'(cfg_q.level_three);
      REG_COUPLING:    prdata = CFG_DW'(cfg_q.coupling_negative);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_one         <= LEVEL_ONE_Q32;
      cfg_q.level_two         <= LEVEL_ONE_Q32;
      cfg_q.level_three       <= LEVEL_ONE_Q32;
      cfg_q.coupling_negative <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[src/itm_lattice_ram.sv]
// ----------------------------------------------------------------------------
// Spin lattice memory
// One-bit-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module itm_lattice_ram import itm_pkg::*; #(
  parameter int DEPTH = ITM_ROWS * ITM_COLS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic                     rdata_o
);

  logic mem [DEPTH];
  logic rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

endmodule

[src/itm_site_addr.sv]
// ----------------------------------------------------------------------------
// Site address generator
// Forms the lattice memory address of a site or one of its six neighbors on
// the periodic triangular lattice.
// ----------------------------------------------------------------------------
module itm_site_addr import itm_pkg::*; #(
  parameter int ROWS = ITM_ROWS,
  parameter int COLS = ITM_COLS
) (
  input  logic [$clog2(ROWS)-1:0]      row_i,
  input  logic [$clog2(COLS)-1:0]      col_i,
  input  nbr_e                         nbr_i,
  output logic [$clog2(ROWS*COLS)-1:0] addr_o
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = $clog2(ROWS * COLS);

  logic [RW-1:0] row_next, row_prev, row_sel;
  logic [CW-1:0] col_next, col_prev, col_sel;

  assign row_next = (row_i == RW'(ROWS - 1)) ? '0 : row_i + RW'(1);
  assign row_prev = (row_i == '0) ? RW'(ROWS - 1) : row_i - RW'(1);
  assign col_next = (col_i == CW'(COLS - 1)) ? '0 : col_i + CW'(1);
  assign col_prev = (col_i == '0) ? CW'(COLS - 1) : col_i - CW'(1);

  always_comb begin
    case (nbr_i)
      NB_CENTER: begin
        row_sel = row_i;
        col_sel = col_i;
      end
      NB_NEXT_ROW: begin
        row_sel = row_next;
        col_sel = col_i;
      end
      NB_PREV_ROW: begin
        row_sel = row_prev;
        col_sel = col_i;
      end
      NB_NEXT_ROW_PREV_COL: begin
        row_sel = row_next;
        col_sel = col_prev;
      end
      NB_PREV_ROW_NEXT_COL: begin
        row_sel = row_prev;
        col_sel = col_next;
      end
      NB_NEXT_COL: begin
        row_sel = row_i;
        col_sel = col_next;
      end
      NB_PREV_COL: begin
        row_sel = row_i;
        col_sel = col_prev;
      end
      default: begin
        row_sel = row_i;
        col_sel = col_i;
      end
    endcase
  end

  assign addr_o = AW'(row_sel) * AW'(COLS) + AW'(col_sel);

endmodule

[src/ising_triangular_metropolis_core.sv]
// ----------------------------------------------------------------------------
// Triangular Ising Metropolis core
// Spin lattice, energy walk, single-site Metropolis trials and a saturating
// sweep energy sum behind one request channel and one result channel.
// ----------------------------------------------------------------------------
// One item is handled at a time; every spin access goes through the single
// read port of the lattice memory, one site per cycle, into a shared +/-1
// bond accumulator. A load reads nothing, an accumulate reads the addressed
// site, a trial reads the site plus six neighbors and an energy walk reads
// the site and three forward neighbors for every site, then the addressed
// site. The lattice has no reset and needs no clearing pass; every site must
// be loaded before it is read. A finished result waits in an output register,
// so the next item is accepted while it is still pending.
`include "assert_macros.svh"

module ising_triangular_metropolis_core import itm_pkg::*; #(
  parameter int ROWS = ITM_ROWS,
  parameter int COLS = ITM_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  itm_in_if.sink            in_i,
  itm_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = $clog2(ROWS * COLS);
  localparam int ACC_W = $clog2(3 * ROWS * COLS + 1) + 1;
  localparam int TOT_W = (ACC_W + 1 > ENERGY_W + 1) ? ACC_W + 1 : ENERGY_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  localparam logic [2:0] K_WALK_LAST  = 3'd3;
  localparam logic [2:0] K_TRIAL_LAST = 3'd6;

  function automatic logic [8:0] wrap_coord(logic [COORD_W-1:0] v, int unsigned lim);
    logic [8:0] w;
    w = 9'(v);
    for (int i = 0; i < 5; i++) begin
      if (w >= 9'(lim)) begin
        w = w - 9'(lim);
      end
    end
    return w;
  endfunction

  cfg_t cfg;

  logic [1:0]                 state_q, state_d;
  op_e                        op_q, op_d;
  logic [RW-1:0]              r_q, r_d;
  logic [CW-1:0]              c_q, c_d;
  logic                       spin_q, spin_d;
  logic [FRAC_W-1:0]          frac_q, frac_d;
  logic [2:0]                 k_q, k_d;
  logic                       walk_q, walk_d;
  logic [RW-1:0]              wr_q, wr_d;
  logic [CW-1:0]              wc_q, wc_d;
  logic                       pend_q, pend_d;
  logic                       pend_center_q, pend_center_d;
  logic                       ctr_q, ctr_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ENERGY_W-1:0] en_q, en_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_spin_q, out_spin_d;
  logic                       out_acc_q, out_acc_d;
  logic signed [ENERGY_W-1:0] out_en_q, out_en_d;
  logic signed [SUM_W-1:0]    out_sum_q, out_sum_d;

  logic                       in_acc;
  logic                       out_free;
  logic                       grp_last;
  nbr_e                       nbr;
  logic [RW-1:0]              site_r;
  logic [CW-1:0]              site_c;
  logic [AW-1:0]              site_addr;
  logic                       mem_we;
  logic                       mem_wd;
  logic                       mem_rd;
  logic signed [ACC_W-1:0]    acc_step;
  logic signed [4:0]          de;
  logic                       flip_ok;
  logic signed [ENERGY_W:0]   en_trial_sum;
  logic signed [ENERGY_W-1:0] en_trial;
  logic signed [TOT_W-1:0]    tot;
  logic signed [ENERGY_W-1:0] en_walk;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_sat;

  itm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  itm_site_addr #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_addr (
    .row_i  (site_r),
    .col_i  (site_c),
    .nbr_i  (nbr),
    .addr_o (site_addr)
  );

  itm_lattice_ram #(
    .DEPTH (ROWS * COLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (site_addr),
    .wdata_i (mem_wd),
    .raddr_i (site_addr),
    .rdata_o (mem_rd)
  );

  assign in_i.ready         = (state_q == ST_IDLE);
  assign in_acc             = in_i.valid & in_i.ready;
  assign out_free           = !out_valid_q | out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.spin_after   = out_spin_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.total_energy = out_en_q;
  assign out_o.energy_sum   = out_sum_q;

  assign site_r = walk_q ? wr_q : r_q;
  assign site_c = walk_q ? wc_q : c_q;

  always_comb begin
    if (walk_q) begin
      case (k_q)
        3'd0:    nbr = NB_CENTER;
        3'd1:    nbr = NB_NEXT_COL;
        3'd2:    nbr = NB_NEXT_ROW;
        3'd3:    nbr = NB_NEXT_ROW_PREV_COL;
        default: nbr = NB_CENTER;
      endcase
      grp_last = (k_q == K_WALK_LAST);
    end else if (op_q == OP_TRIAL) begin
      nbr      = nbr_e'(k_q);
      grp_last = (k_q == K_TRIAL_LAST);
    end else begin
      nbr      = NB_CENTER;
      grp_last = 1'b1;
    end
  end

  assign acc_step = (ctr_q == mem_rd) ? ACC_W'(1) : {ACC_W{1'b1}};

  // Flip energy change in |J| units: -2 (+2 for negative J) times bond sum.
  assign de = cfg.coupling_negative ? (acc_q[4:0] <<< 1) : -(acc_q[4:0] <<< 1);

  always_comb begin
    if (de <= 5'sd0) begin
      flip_ok = 1'b1;
    end else if (de <= 5'sd4) begin
      flip_ok = {1'b0, frac_q} <= cfg.level_one;
    end else if (de <= 5'sd8) begin
      flip_ok = {1'b0, frac_q} <= cfg.level_two;
    end else begin
      flip_ok = {1'b0, frac_q} <= cfg.level_three;
    end
  end

  always_comb begin
    en_trial_sum = (ENERGY_W + 1)'(en_q) + (ENERGY_W + 1)'(de);
    if (en_trial_sum > (ENERGY_W + 1)'(ENERGY_MAX)) begin
      en_trial = ENERGY_W'(ENERGY_MAX);
    end else if (en_trial_sum < (ENERGY_W + 1)'(ENERGY_MIN)) begin
      en_trial = ENERGY_W'(ENERGY_MIN);
    end else begin
      en_trial = en_trial_sum[ENERGY_W-1:0];
    end
  end

  always_comb begin
    tot = cfg.coupling_negative ? -TOT_W'(acc_q) : TOT_W'(acc_q);
    if (tot > TOT_W'(ENERGY_MAX)) begin
      en_walk = ENERGY_W'(ENERGY_MAX);
    end else if (tot < TOT_W'(ENERGY_MIN)) begin
      en_walk = ENERGY_W'(ENERGY_MIN);
    end else begin
      en_walk = tot[ENERGY_W-1:0];
    end
  end

  always_comb begin
    sum_wide = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(en_q);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    r_d           = r_q;
    c_d           = c_q;
    spin_d        = spin_q;
    frac_d        = frac_q;
    k_d           = k_q;
    walk_d        = walk_q;
    wr_d          = wr_q;
    wc_d          = wc_q;
    pend_d        = 1'b0;
    pend_center_d = 1'b0;
    ctr_d         = ctr_q;
    acc_d         = acc_q;
    en_d          = en_q;
    sum_d         = sum_q;
    out_valid_d   = out_valid_q & ~out_o.ready;
    out_spin_d    = out_spin_q;
    out_acc_d     = out_acc_q;
    out_en_d      = out_en_q;
    out_sum_d     = out_sum_q;
    mem_we        = 1'b0;
    mem_wd        = 1'b0;

    if (pend_q) begin
      if (pend_center_q) begin
        ctr_d = mem_rd;
      end else begin
        acc_d = acc_q + acc_step;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = op_e'(in_i.operation);
          r_d     = RW'(wrap_coord(in_i.row, ROWS));
          c_d     = CW'(wrap_coord(in_i.col, COLS));
          spin_d  = in_i.spin_up;
          frac_d  = in_i.random_fraction;
          acc_d   = '0;
          k_d     = '0;
          wr_d    = '0;
          wc_d    = '0;
          walk_d  = (op_e'(in_i.operation) == OP_ENERGY);
          state_d = (op_e'(in_i.operation) == OP_LOAD) ? ST_EXEC : ST_READ;
        end
      end
      ST_READ: begin
        pend_d        = 1'b1;
        pend_center_d = (k_q == '0);
        if (grp_last) begin
          k_d = '0;
          if (walk_q) begin
            if (wc_q == CW'(COLS - 1)) begin
              wc_d = '0;
              if (wr_q == RW'(ROWS - 1)) begin
                walk_d = 1'b0;
              end else begin
                wr_d = wr_q + RW'(1);
              end
            end else begin
              wc_d = wc_q + CW'(1);
            end
          end else begin
            state_d = ST_DRAIN;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          out_spin_d = ctr_q;
          out_acc_d  = 1'b0;
          case (op_q)
            OP_LOAD: begin
              mem_we     = 1'b1;
              mem_wd     = spin_q;
              out_spin_d = spin_q;
            end
            OP_ENERGY: begin
              en_d = en_walk;
            end
            OP_TRIAL: begin
              if (flip_ok) begin
                mem_we = 1'b1;
                mem_wd = ~ctr_q;
                en_d   = en_trial;
              end
              out_spin_d = ctr_q ^ flip_ok;
              out_acc_d  = flip_ok;
            end
            OP_ACCUM: begin
              sum_d = sum_sat;
            end
            default: begin
              en_d = en_q;
            end
          endcase
          out_en_d    = en_d;
          out_sum_d   = sum_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      k_q           <= '0;
      walk_q        <= 1'b0;
      wr_q          <= '0;
      wc_q          <= '0;
      pend_q        <= 1'b0;
      pend_center_q <= 1'b0;
      en_q          <= '0;
      sum_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      k_q           <= k_d;
      walk_q        <= walk_d;
      wr_q          <= wr_d;
      wc_q          <= wc_d;
      pend_q        <= pend_d;
      pend_center_q <= pend_center_d;
      en_q          <= en_d;
      sum_q         <= sum_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    r_q        <= r_d;
    c_q        <= c_d;
    spin_q     <= spin_d;
    frac_q     <= frac_d;
    ctr_q      <= ctr_d;
    acc_q      <= acc_d;
    out_spin_q <= out_spin_d;
    out_acc_q  <= out_acc_d;
    out_en_q   <= out_en_d;
    out_sum_q  <= out_sum_d;
  end

  `ITM_ASSERT(a_energy_in_range, clk_i, rst_ni, (en_q >= ENERGY_MIN) && (en_q <= ENERGY_MAX), "running energy left its range")
  `ITM_ASSERT_NEVER(a_no_read_at_commit, clk_i, rst_ni, pend_q && ((state_q == ST_EXEC) || (state_q == ST_IDLE)), "lattice read still in flight at commit")
  `ITM_ASSERT(a_walk_only_reading, clk_i, rst_ni, walk_q |-> (state_q == ST_READ), "energy walk active outside the read phase")

endmodule
